/* hdl/hce_pkg.sv */
// Shared types and constants for the Hill cipher encryptor.
// Depends on nothing; every other file in hdl/ imports it.
`timescale 1ns / 1ps

package hce_pkg;

    localparam int LETTER_W      = 5;
    localparam int KEY_DIM       = 4;
    localparam int KEY_ROW_W     = KEY_DIM * LETTER_W;
    localparam int MAX_BLOCK_DEF = 4;
    localparam int BSIZE_W       = 3;
    localparam int ALPHA         = 26;
    // up to four products of two reduced letters: 4 * 25 * 25 < 2**12
    localparam int SUM_W         = 12;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    typedef enum logic [2:0] {
        REG_BLOCK_SIZE = 3'd0,
        REG_KEY_ROW0   = 3'd1,
        REG_KEY_ROW1   = 3'd2,
        REG_KEY_ROW2   = 3'd3,
        REG_KEY_ROW3   = 3'd4
    } hce_reg_t;

    // Configuration as seen by the datapath: effective block size and key rows
    typedef struct packed {
        logic [BSIZE_W-1:0]                blk_n;
        logic [KEY_DIM-1:0][KEY_ROW_W-1:0] key;
    } hce_cfg_t;

endpackage

/* hdl/hce_front.sv */
// Front end: accepts letter items, collects them into a block, pushes full blocks.
// Depends on hce_pkg.
`timescale 1ns / 1ps

module hce_front
    import hce_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [BSIZE_W-1:0]                blk_n,
    input  logic                              clear,
    input  logic                              letter_valid,
    output logic                              letter_stall,
    input  logic [LETTER_W-1:0]               letter_code,
    input  logic                              end_of_text,
    output logic                              q_push,
    output logic [((MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM)*LETTER_W-1:0] q_data,
    input  logic                              q_full
);

    localparam int CAP   = (MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

    logic [CAP-1:0][LETTER_W-1:0] buf_reg;
    logic [IDX_W-1:0]             fill_reg;
    logic [IDX_W-1:0]             fill_next;
    logic [IDX_W-1:0]             idx;
    logic                         accept;
    logic                         blk_done;

    assign letter_stall = q_full;
    assign accept       = letter_valid && !letter_stall;

    // the fill count never reaches n in practice; wrap anyway
    assign idx      = (BSIZE_W'(fill_reg) >= blk_n) ? '0 : fill_reg;
    assign blk_done = (BSIZE_W'(idx) + BSIZE_W'(1)) == blk_n;
    assign q_push   = accept && !end_of_text && blk_done;

    always_comb
    begin
        for (int j = 0; j < CAP; j++)
        begin
            q_data[j*LETTER_W +: LETTER_W] = (IDX_W'(j) == idx) ? letter_code : buf_reg[j];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (clear)
        begin
            fill_next = '0;
        end
        else if (accept)
        begin
            if (end_of_text || blk_done)
            begin
                fill_next = '0;
            end
            else
            begin
                fill_next = idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !end_of_text)
        begin
            for (int j = 0; j < CAP; j++)
            begin
                if (IDX_W'(j) == idx)
                begin
                    buf_reg[j] <= letter_code;
                end
            end
        end
    end

endmodule

/* hdl/hce_queue.sv */
// Two-entry block queue between the front end and the matrix unit.
// Depends on hce_pkg for the constants in its default WIDTH only.
`timescale 1ns / 1ps

module hce_queue
    import hce_pkg::*;
#(
    parameter int WIDTH = MAX_BLOCK_DEF * LETTER_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    logic [1:0][WIDTH-1:0] mem_reg;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;

    assign full      = count_reg == 2'd2;
    assign empty     = count_reg == 2'd0;
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/hce_back.sv */
// Matrix unit: one key row dot product per cycle unless stalled, then mod 26, into the
// output register. Depends on hce_pkg.
`timescale 1ns / 1ps

module hce_back
    import hce_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hce_cfg_t             cfg,
    input  logic                 q_empty,
    input  logic [((MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM)*LETTER_W-1:0] q_data,
    output logic                 q_pop,
    output logic                 cipher_valid,
    input  logic                 cipher_stall,
    output logic [LETTER_W-1:0]  cipher_code,
    output logic                 block_last
);

    localparam int CAP   = (MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

    // letters and key entries may be 26..31
    function automatic logic [LETTER_W-1:0] fold26(input logic [LETTER_W-1:0] v);
        return (v >= LETTER_W'(ALPHA)) ? v - LETTER_W'(ALPHA) : v;
    endfunction

    // x < 2**12: floor(x/26) = (x * 2521) >> 16 over that range
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
        logic [2*SUM_W-1:0] prod;
        logic [7:0]         q;
        logic [SUM_W-1:0]   q26;
        prod = (2*SUM_W)'(x) * (2*SUM_W)'(2521);
        q    = prod[23:16];
        q26  = {q, 4'b0} + {1'b0, q, 3'b0} + {3'b0, q, 1'b0};
        return LETTER_W'(x - q26);
    endfunction

    logic [IDX_W-1:0]     row_reg;
    logic                 adv;
    logic                 issue;
    logic                 row_last;
    logic [KEY_ROW_W-1:0] key_row;
    logic [SUM_W-1:0]     dot;

    logic                 a_vld_reg;
    logic                 a_last_reg;
    logic [SUM_W-1:0]     a_sum_reg;

    logic                 o_vld_reg;
    logic                 o_last_reg;
    logic [LETTER_W-1:0]  o_code_reg;

    assign adv      = !o_vld_reg || !cipher_stall;
    assign issue    = adv && !q_empty;
    assign row_last = (BSIZE_W'(row_reg) + BSIZE_W'(1)) == cfg.blk_n;
    assign q_pop    = issue && row_last;
    assign key_row  = cfg.key[2'(row_reg)];

    always_comb
    begin
        dot = '0;
        for (int k = 0; k < CAP; k++)
        begin
            if (BSIZE_W'(k) < cfg.blk_n)
            begin
                dot = dot + SUM_W'(fold26(key_row[k*LETTER_W +: LETTER_W]))
                          * SUM_W'(fold26(q_data[k*LETTER_W +: LETTER_W]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= issue;
            o_vld_reg <= a_vld_reg;
            if (issue)
            begin
                row_reg <= row_last ? '0 : row_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sum_reg  <= dot;
            a_last_reg <= row_last;
            o_code_reg <= mod26(a_sum_reg);
            o_last_reg <= a_last_reg;
        end
    end

    assign cipher_valid = o_vld_reg;
    assign cipher_code  = o_code_reg;
    assign block_last   = o_last_reg;

endmodule

/* hdl/hill_cipher_encrypt.sv */
// Hill cipher encryptor: a block completed by a letter item passes the queue, sum and
// output registers to its first cipher item; the other rows follow one a cycle, and
// sustained rate one letter per cycle, set by the matrix unit's one key row per cycle,
// both when not stalled; a two-block queue decouples letter intake from cipher output.
// Reset: block size 2, identity key, no partial block; buffered letters undefined.
`timescale 1ns / 1ps

module hill_cipher_encrypt
    import hce_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                letter_valid,
    output logic                letter_stall,
    input  logic [LETTER_W-1:0] letter_code,
    input  logic                end_of_text,
    output logic                cipher_valid,
    input  logic                cipher_stall,
    output logic [LETTER_W-1:0] cipher_code,
    output logic                block_last
);

    localparam int CAP    = (MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM;
    localparam int BLK_W  = CAP * LETTER_W;

    logic [BSIZE_W-1:0]                block_size_reg;
    logic [KEY_DIM-1:0][KEY_ROW_W-1:0] key_reg;
    logic                              cfg_wr;
    hce_reg_t                          reg_sel;
    logic                              blk_clear;
    logic [BSIZE_W-1:0]                eff_n;
    hce_cfg_t                          cfg;

    logic                              q_push;
    logic                              q_pop;
    logic                              q_full;
    logic                              q_empty;
    logic [BLK_W-1:0]                  q_wdata;
    logic [BLK_W-1:0]                  q_rdata;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_sel   = hce_reg_t'(paddr[4:2]);
    assign blk_clear = cfg_wr && (reg_sel == REG_BLOCK_SIZE);

    // zero acts as one, anything past the buffer depth as the depth
    assign eff_n = (block_size_reg == '0)              ? BSIZE_W'(1) :
                   (block_size_reg > BSIZE_W'(CAP))    ? BSIZE_W'(CAP) :
                                                         block_size_reg;

    assign cfg = {eff_n, key_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BSIZE_W'(2);
            key_reg[0]     <= KEY_ROW_W'(1);
            key_reg[1]     <= KEY_ROW_W'(32);
            key_reg[2]     <= KEY_ROW_W'(1024);
            key_reg[3]     <= KEY_ROW_W'(32768);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_BLOCK_SIZE: block_size_reg <= pwdata[BSIZE_W-1:0];
                REG_KEY_ROW0:   key_reg[0]     <= pwdata[KEY_ROW_W-1:0];
                REG_KEY_ROW1:   key_reg[1]     <= pwdata[KEY_ROW_W-1:0];
                REG_KEY_ROW2:   key_reg[2]     <= pwdata[KEY_ROW_W-1:0];
                REG_KEY_ROW3:   key_reg[3]     <= pwdata[KEY_ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BLOCK_SIZE: prdata = PDATA_W'(block_size_reg);
            REG_KEY_ROW0:   prdata = PDATA_W'(key_reg[0]);
            REG_KEY_ROW1:   prdata = PDATA_W'(key_reg[1]);
            REG_KEY_ROW2:   prdata = PDATA_W'(key_reg[2]);
            REG_KEY_ROW3:   prdata = PDATA_W'(key_reg[3]);
            default:        prdata = '0;
        endcase
    end

    hce_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .blk_n        (eff_n),
        .clear        (blk_clear),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter_code  (letter_code),
        .end_of_text  (end_of_text),
        .q_push       (q_push),
        .q_data       (q_wdata),
        .q_full       (q_full)
    );

    hce_queue #(
        .WIDTH (BLK_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head_data (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    hce_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_code  (cipher_code),
        .block_last   (block_last)
    );

endmodule

/* hdl/hce_checker.sv */
// Port-level checks for the Hill cipher encryptor, bound to the top level.
// Depends on hce_pkg and hill_cipher_encrypt.
`timescale 1ns / 1ps

module hce_checker
    import hce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cipher_valid,
    input  logic                cipher_stall,
    input  logic [LETTER_W-1:0] cipher_code,
    input  logic                block_last
);

    // a waiting item stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && cipher_stall |=> cipher_valid)
        else $error("cipher item withdrawn while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && cipher_stall |=> $stable(cipher_code) && $stable(block_last))
        else $error("cipher item changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid |-> cipher_code <= LETTER_W'(ALPHA - 1))
        else $error("cipher code not reduced mod 26");

    // rows of one block leave without gaps once a row has been taken
    a_row_run: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && !cipher_stall && !block_last |=> cipher_valid)
        else $error("gap inside a block's output run");

endmodule

bind hill_cipher_encrypt hce_checker u_hce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher_code  (cipher_code),
    .block_last   (block_last)
);

/* dv/hill_cipher_encrypt_test.sv */
// Self-checking testbench for hill_cipher_encrypt: letter items in, cipher items out.
// Predicts each block's cipher letters in step with the APB register writes it sees.
// Depends on hce_pkg and the hill_cipher_encrypt RTL.
`timescale 1ns / 1ps

module hill_cipher_encrypt_test;
    import hce_pkg::*;

    localparam int BLOCK_CAP   = (MAX_BLOCK_DEF < KEY_DIM) ? MAX_BLOCK_DEF : KEY_DIM;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;
    localparam int LETTER_GOAL = 310;

    typedef struct packed {
        logic [LETTER_W-1:0] code;
        logic                eot;
    } letter_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] code;
        logic                last;
    } cipher_item_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                letter_valid = 1'b0;
    logic                letter_stall;
    logic [LETTER_W-1:0] letter_code = '0;
    logic                end_of_text = 1'b0;
    logic                cipher_valid;
    logic                cipher_stall = 1'b0;
    logic [LETTER_W-1:0] cipher_code;
    logic                block_last;

    hill_cipher_encrypt dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter_code  (letter_code),
        .end_of_text  (end_of_text),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_code  (cipher_code),
        .block_last   (block_last)
    );

    // pending stimulus and outstanding cipher predictions
    letter_item_t letter_items[$];
    cipher_item_t cipher_expected[$];

    // predictor copy of the block's registers and state
    logic [BSIZE_W-1:0]   size_reg = 3'd2;
    logic [KEY_ROW_W-1:0] key_reg[KEY_DIM] = '{20'd1, 20'd32, 20'd1024, 20'd32768};
    logic [LETTER_W-1:0]  held[BLOCK_CAP];
    int                   held_cnt = 0;

    int pushed_count = 0;
    int taken_count  = 0;
    int taken_seen   = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int calm_left[2] = '{0, 0};
    int errors       = 0;
    int checked      = 0;
    int letters_sent = 0;
    int eots_sent    = 0;
    int cfg_writes   = 0;
    int cycles       = 0;
    logic [BSIZE_W-1:0] stim_size = 3'd2;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int eff_size(logic [BSIZE_W-1:0] raw);
        int n;
        n = raw;
        if (n == 0)
            n = 1;
        if (n > BLOCK_CAP)
            n = BLOCK_CAP;
        return n;
    endfunction

    function automatic logic [KEY_ROW_W-1:0] pack_key(int e0, int e1, int e2, int e3);
        return {5'(e3), 5'(e2), 5'(e1), 5'(e0)};
    endfunction

    function automatic logic [KEY_ROW_W-1:0] rand_key_row();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        if (r == 2)
            return KEY_ROW_W'($urandom);
        return pack_key($urandom_range(0, 25), $urandom_range(0, 25),
                        $urandom_range(0, 25), $urandom_range(0, 25));
    endfunction

    // mostly no gap, some short, a few long; occasional calm stretches with none
    function automatic int next_gap(int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left[side] = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic encrypt_step(logic [LETTER_W-1:0] code, logic eot);
        int n;
        int acc;
        cipher_item_t c;
        n = eff_size(size_reg);
        if (eot)
        begin
            held_cnt = 0;
            return;
        end
        if (held_cnt >= n)
            held_cnt = 0;
        held[held_cnt] = code;
        held_cnt++;
        if (held_cnt < n)
            return;
        for (int i = 0; i < n; i++)
        begin
            acc = 0;
            for (int k = 0; k < n; k++)
                acc += int'(key_reg[i][5*k +: 5]) * int'(held[k]);
            c.code = LETTER_W'(acc % ALPHA);
            c.last = (i == n - 1);
            cipher_expected.push_back(c);
        end
        held_cnt = 0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // predictor, acceptance tracking and result check
    always @(posedge clk)
    begin
        cipher_item_t exp_c;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (hce_reg_t'(paddr[4:2]))
                    REG_BLOCK_SIZE:
                    begin
                        size_reg = pwdata[BSIZE_W-1:0];
                        held_cnt = 0;
                    end
                    REG_KEY_ROW0: key_reg[0] = pwdata[KEY_ROW_W-1:0];
                    REG_KEY_ROW1: key_reg[1] = pwdata[KEY_ROW_W-1:0];
                    REG_KEY_ROW2: key_reg[2] = pwdata[KEY_ROW_W-1:0];
                    REG_KEY_ROW3: key_reg[3] = pwdata[KEY_ROW_W-1:0];
                    default: ;
                endcase
            end
            if (letter_valid && !letter_stall)
            begin
                encrypt_step(letter_code, end_of_text);
                taken_count++;
            end
            if (cipher_valid && !cipher_stall)
            begin
                if (cipher_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected cipher item: code %0d last %0b",
                                 cipher_code, block_last);
                end
                else
                begin
                    exp_c = cipher_expected.pop_front();
                    checked++;
                    if (exp_c.code !== cipher_code || exp_c.last !== block_last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("cipher mismatch: expected code %0d last %0b,",
                                     exp_c.code, exp_c.last,
                                     " got code %0d last %0b",
                                     cipher_code, block_last);
                    end
                end
            end
        end
    end

    // letter driver: holds an item until taken, then gap or next item
    always @(negedge clk)
    begin
        letter_item_t it;
        if (!rst_n)
            letter_valid <= 1'b0;
        else if (!(letter_valid && taken_count == taken_seen))
        begin
            taken_seen = taken_count;
            if (send_gap > 0)
            begin
                letter_valid <= 1'b0;
                send_gap--;
            end
            else if (letter_items.size() > 0)
            begin
                it = letter_items.pop_front();
                letter_code  <= it.code;
                end_of_text  <= it.eot;
                letter_valid <= 1'b1;
                send_gap = next_gap(0);
            end
            else
                letter_valid <= 1'b0;
        end
    end

    // cipher side back-pressure
    always @(negedge clk)
    begin
        int g;
        if (!rst_n)
            cipher_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            cipher_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            g = next_gap(1);
            cipher_stall <= (g > 0);
            if (g > 0)
                stall_left = g - 1;
        end
    end

    task automatic cfg_write(hce_reg_t idx, logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BLOCK_SIZE)
            stim_size = val[BSIZE_W-1:0];
        cfg_writes++;
    endtask

    task automatic send_letter(int code);
        letter_items.push_back('{code: LETTER_W'(code), eot: 1'b0});
        pushed_count++;
        letters_sent++;
    endtask

    task automatic send_eot(int code);
        letter_items.push_back('{code: LETTER_W'(code), eot: 1'b1});
        pushed_count++;
        eots_sent++;
    endtask

    // sender holds off until every letter is taken and every cipher item is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (taken_count != pushed_count || cipher_expected.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic int rand_letter();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(0, 25);
        return $urandom_range(26, 31);
    endfunction

    initial
    begin
        int n;
        int r;
        int phase_items;
        int target;
        int len;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset key (identity), size 2: extremes, out-of-range letters, end of text
        send_letter(0);
        send_letter(25);
        send_letter(31);
        send_letter(26);
        send_letter(3);
        send_eot(31);
        send_eot(0);
        send_letter(7);   // left pending across the key change below
        wait_idle();

        // key rewritten with a letter held: the new key applies to that block
        cfg_write(REG_KEY_ROW0, pack_key(25, 25, 25, 25));
        cfg_write(REG_KEY_ROW1, '1);
        cfg_write(REG_KEY_ROW2, '0);
        cfg_write(REG_KEY_ROW3, pack_key(3, 26, 0, 17));
        send_letter(19);
        wait_idle();

        cfg_write(REG_BLOCK_SIZE, 4);
        repeat (4) send_letter(25);
        send_letter(31);
        send_letter(0);
        send_letter(31);
        send_letter(0);
        wait_idle();

        // size 0 acts as 1
        cfg_write(REG_BLOCK_SIZE, 0);
        send_letter(25);
        send_letter(12);
        wait_idle();

        // oversize clamps to the cap
        cfg_write(REG_BLOCK_SIZE, 7);
        send_letter(1);
        send_letter(2);
        send_letter(3);
        send_letter(4);
        wait_idle();

        cfg_write(REG_BLOCK_SIZE, 3);
        cfg_write(REG_KEY_ROW1, rand_key_row());
        send_letter(30);
        send_letter(0);
        send_letter(25);
        wait_idle();

        // random phases: mostly whole blocks, some dropped partials and lone end of text
        while (pushed_count < LETTER_GOAL)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r = $urandom_range(0, 9);
                if (r < 8)
                    cfg_write(REG_BLOCK_SIZE, $urandom_range(1, 4));
                else
                begin
                    r = $urandom_range(0, 3);
                    cfg_write(REG_BLOCK_SIZE, (r == 0) ? 0 : r + 4);
                end
            end
            for (int row = 0; row < KEY_DIM; row++)
                if ($urandom_range(0, 1))
                    cfg_write(hce_reg_t'(int'(REG_KEY_ROW0) + row), rand_key_row());
            phase_items = 0;
            target = $urandom_range(25, 45);
            while (phase_items < target)
            begin
                n = eff_size(stim_size);
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    repeat (n) send_letter(rand_letter());
                    phase_items += n;
                end
                else if (r < 93)
                begin
                    len = $urandom_range(0, n - 1);
                    repeat (len) send_letter(rand_letter());
                    send_eot($urandom_range(0, 31));
                    phase_items += len + 1;
                end
                else
                begin
                    send_eot($urandom_range(0, 31));
                    phase_items++;
                end
            end
            wait_idle();
        end

        errors += cipher_expected.size();
        $display("Sent %0d letters and %0d end-of-text items across %0d register writes;",
                 letters_sent, eots_sent, cfg_writes);
        $display("checked %0d cipher items, %0d errors.", checked, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
